[rtl/core/kscq_pkg.sv]
// Shared types, constants and scan-code translation for the keyboard scancode ring queue.
package kscq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TABLE_LEN   = 58;

    localparam logic [7:0] RELEASE_BIT  = 8'h80;
    localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;

    localparam logic [7:0] SET1_TABLE [0:TABLE_LEN-1] = '{
        8'h3F, 8'h3F, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h3F, 8'h3F, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h3F, 8'h3F,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h27, 8'h60, 8'h3F, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h3F, 8'h3F, 8'h3F, 8'h20
    };

    typedef struct packed {
        logic       push;
        logic       rd_en;
        logic [7:0] ch;
    } kscq_op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } kscq_status_t;

    function automatic logic [7:0] kscq_translate(input logic [6:0] code);
        logic [7:0] ch;
        if (code < 7'(TABLE_LEN)) begin
            ch = SET1_TABLE[code[5:0]];
        end else begin
            ch = UNKNOWN_CHAR;
        end
        return ch;
    endfunction

    function automatic logic [PTR_W-1:0] kscq_next_pos(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

[rtl/core/kscq_ring.sv]
// Overwrite-oldest ring store with head/tail pointers, fill count and registered read.
module kscq_ring (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kscq_pkg::kscq_op_t    op,
    output kscq_pkg::kscq_status_t status,
    output logic [7:0]            rd_data
);
    import kscq_pkg::*;

    logic [7:0]       mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [7:0]       rd_data_reg;
    logic             empty;
    logic             full;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (op.push) begin
            tail_next = kscq_next_pos(tail_reg);
            if (full) begin
                head_next = kscq_next_pos(head_reg);
            end else begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end else if (op.rd_en && !empty) begin
            head_next = kscq_next_pos(head_reg);
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.push) begin
            mem[tail_reg] <= op.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.rd_en) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign status.empty = empty;
    assign status.full  = full;
    assign rd_data      = rd_data_reg;

endmodule

[rtl/core/kscq_pipe.sv]
// Input beat register, request decode and result register with valid/ready handshakes.
module kscq_pipe (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic                   s_data_ready,
    input  logic [7:0]             s_scancode,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_key_valid,
    output logic [7:0]             m_key_char,
    output kscq_pkg::kscq_op_t     op,
    input  kscq_pkg::kscq_status_t status,
    input  logic [7:0]             rd_data
);
    import kscq_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic       func_reg;
    logic       ready_reg;
    logic [7:0] code_reg;
    logic       out_valid_reg, out_valid_next;
    logic       key_valid_reg, key_valid_next;
    logic       out_free;
    logic       advance;
    logic       take;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!func_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign take     = s_valid && s_ready;

    assign op.push  = advance && !func_reg && ready_reg && ((code_reg & RELEASE_BIT) == '0);
    assign op.rd_en = advance && func_reg;
    assign op.ch    = kscq_translate(code_reg[6:0]);

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        key_valid_next = key_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (op.rd_en) begin
            out_valid_next = 1'b1;
            key_valid_next = !status.empty;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            key_valid_reg <= key_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            func_reg  <= s_func;
            ready_reg <= s_data_ready;
            code_reg  <= s_scancode;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_key_valid = key_valid_reg;
    assign m_key_char  = key_valid_reg ? rd_data : 8'h00;

endmodule

[rtl/core/keyboard_scancode_ring_queue_core.sv]
// Top level of the keyboard scancode ring queue: set-1 translation into an overwrite FIFO.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_func, s_data_ready, s_scancode
//  m_       out        m_valid / m_ready  m_key_valid, m_key_char
//
// One beat per cycle unless a read waits on a stalled result; a read goes input register, then result register.
// Key events finish in the input register stage and never wait on the result side.
// A read beat holds in the input register while the result register is full and stalled.
// Synchronous active-low reset empties the queue; store contents are not cleared.
module keyboard_scancode_ring_queue_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic       s_data_ready,
    input  logic [7:0] s_scancode,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_key_valid,
    output logic [7:0] m_key_char
);
    import kscq_pkg::*;

    kscq_op_t     op;
    kscq_status_t status;
    logic [7:0]   rd_data;

    kscq_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_data_ready (s_data_ready),
        .s_scancode   (s_scancode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_valid  (m_key_valid),
        .m_key_char   (m_key_char),
        .op           (op),
        .status       (status),
        .rd_data      (rd_data)
    );

    kscq_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .status  (status),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    a_push_xor_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({op.push, op.rd_en}))
        else $error("push and read issued in the same cycle");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full |-> !status.empty)
        else $error("queue reports full and empty together");

    a_empty_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_key_valid) |-> (m_key_char == 8'h00))
        else $error("empty read returned a nonzero character");

    a_read_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        op.rd_en |=> m_valid)
        else $error("read request did not produce a result beat");
`endif

endmodule

[tb/tb_keyboard_scancode_ring_queue_core.sv]
// Testbench for the keyboard scancode ring queue: self-checking, with random idling on both channels.
`timescale 1ns / 100ps

module tb_keyboard_scancode_ring_queue_core;

    localparam int KEY_DEPTH  = 256;
    localparam int IDLE_LIMIT = 200;
    localparam int DRAIN_WAIT = 8;

    localparam logic       FUNC_EVENT = 1'b0;
    localparam logic       FUNC_READ  = 1'b1;
    localparam logic [7:0] BREAK_FLAG = 8'h80;
    localparam logic [7:0] QMARK      = 8'h3F;
    localparam int         MAP_LEN    = 58;

    localparam bit [MAP_LEN*8-1:0] SET1_ASCII =
        "??1234567890-=??QWERTYUIOP[]??ASDFGHJKL;'`?\\ZXCVBNM,./??? ";

    typedef struct {
        logic       key_valid;
        logic [7:0] key_char;
    } key_read_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_func;
    logic       s_data_ready;
    logic [7:0] s_scancode;
    logic       m_valid;
    logic       m_ready;
    logic       m_key_valid;
    logic [7:0] m_key_char;

    logic [7:0] key_ring [KEY_DEPTH];
    int         ring_head;
    int         ring_tail;
    int         ring_fill;
    key_read_t  pending_reads [$];
    int         error_count;
    bit         idle_en;

    keyboard_scancode_ring_queue_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_data_ready (s_data_ready),
        .s_scancode   (s_scancode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_valid  (m_key_valid),
        .m_key_char   (m_key_char)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] set1_to_ascii(input logic [7:0] code);
        int idx;
        idx = int'(code);
        if (idx < MAP_LEN) begin
            return SET1_ASCII[(MAP_LEN - 1 - idx)*8 +: 8];
        end
        return QMARK;
    endfunction

    task automatic predict_beat(input logic func, input logic rdy, input logic [7:0] code);
        key_read_t rd;
        if (func == FUNC_EVENT) begin
            if (rdy && (code & BREAK_FLAG) == 8'h00) begin
                if (ring_fill >= KEY_DEPTH) begin
                    ring_head = (ring_head + 1) % KEY_DEPTH;
                end else begin
                    ring_fill++;
                end
                key_ring[ring_tail] = set1_to_ascii(code);
                ring_tail = (ring_tail + 1) % KEY_DEPTH;
            end
        end else begin
            if (ring_fill == 0) begin
                rd.key_valid = 1'b0;
                rd.key_char  = 8'h00;
            end else begin
                rd.key_valid = 1'b1;
                rd.key_char  = key_ring[ring_head];
                ring_head = (ring_head + 1) % KEY_DEPTH;
                ring_fill--;
            end
            pending_reads.push_back(rd);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_beat(input logic func, input logic rdy, input logic [7:0] code);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_func       <= func;
        s_data_ready <= rdy;
        s_scancode   <= code;
        do @(posedge aclk); while (!s_ready);
        predict_beat(func, rdy, code);
    endtask

    task automatic send_key(input logic [7:0] code);
        send_beat(FUNC_EVENT, 1'b1, code);
    endtask

    task automatic send_read();
        send_beat(FUNC_READ, 1'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
    endtask

    // result check
    always @(posedge aclk) begin
        key_read_t exp_rd;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch($sformatf("unexpected beat valid=%0b char=%02h",
                                          m_key_valid, m_key_char));
            end else begin
                exp_rd = pending_reads.pop_front();
                if (m_key_valid !== exp_rd.key_valid) begin
                    report_mismatch($sformatf("key_valid got %0b want %0b",
                                              m_key_valid, exp_rd.key_valid));
                end
                if (m_key_char !== exp_rd.key_char) begin
                    report_mismatch($sformatf("key_char got %02h want %02h",
                                              m_key_char, exp_rd.key_char));
                end
            end
        end
    end

    // result-side backpressure
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = idle_en ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic test_directed();
        logic [7:0] codes [7];
        codes = '{8'h00, 8'h02, 8'h10, 8'h39, 8'h3A, 8'h7F, 8'h2B};
        idle_en = 1'b1;
        send_read();
        send_key(8'h9E);
        send_key(8'hFF);
        send_beat(FUNC_EVENT, 1'b0, 8'h1E);
        foreach (codes[i]) send_key(codes[i]);
        repeat (8) send_read();
        wait_drained();
    endtask

    task automatic test_queue_wrap();
        idle_en = 1'b0;
        repeat (KEY_DEPTH + 14) send_key({1'b0, 7'($urandom)});
        idle_en = 1'b1;
        repeat (KEY_DEPTH + 4) send_read();
    endtask

    task automatic test_random_mix();
        int sel;
        for (int i = 0; i < 200; i++) begin
            idle_en = !(i >= 40 && i < 80);
            if (i == 120) wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_key({1'b0, 7'($urandom)});
            end else if (sel < 85) begin
                send_read();
            end else begin
                send_beat(FUNC_EVENT, 1'($urandom), 8'($urandom));
            end
        end
        idle_en = 1'b1;
        repeat (KEY_DEPTH + 2) send_read();
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = FUNC_EVENT;
        s_data_ready = 1'b0;
        s_scancode   = 8'h00;
        ring_head    = 0;
        ring_tail    = 0;
        ring_fill    = 0;
        error_count  = 0;
        idle_en      = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_queue_wrap();
        test_random_mix();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
